FILE: design/mpsc_pkg.sv
// shared types, widths and codes for the message part sequence checker
`default_nettype none

package mpsc_pkg;

   // field widths
   localparam int ID_W    = 64;
   localparam int FLAGS_W = 32;
   localparam int KIND_W  = 3;
   localparam int SIZE_W  = 16;
   localparam int VSIZE_W = 32;
   localparam int STAT_W  = 2;
   localparam int CAUSE_W = 4;

   // fixed part geometry
   localparam int PART_HDR_SIZE      = 4;
   localparam int METHOD_MIN_SIZE    = 8;
   localparam int MODIFIER_HEAD_SIZE = 12;

   // part kinds
   localparam logic [KIND_W-1:0] KIND_METHOD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MODIFIER = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MOD_CONT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DATA     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd5;

   // result status
   localparam logic [STAT_W-1:0] STAT_DELIVERED = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ERROR     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_DROPPED   = 2'd2;

   // error causes
   localparam logic [CAUSE_W-1:0] CAUSE_NONE         = 4'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_ID           = 4'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_FLAGS        = 4'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_SIZE         = 4'd3;
   localparam logic [CAUSE_W-1:0] CAUSE_TYPE         = 4'd4;
   localparam logic [CAUSE_W-1:0] CAUSE_MIN_SIZE     = 4'd5;
   localparam logic [CAUSE_W-1:0] CAUSE_METHOD_ORDER = 4'd6;
   localparam logic [CAUSE_W-1:0] CAUSE_METHOD_TERM  = 4'd7;
   localparam logic [CAUSE_W-1:0] CAUSE_MOD_ORDER    = 4'd8;
   localparam logic [CAUSE_W-1:0] CAUSE_MOD_FORMAT   = 4'd9;
   localparam logic [CAUSE_W-1:0] CAUSE_CONT         = 4'd10;
   localparam logic [CAUSE_W-1:0] CAUSE_DATA         = 4'd11;

   // one part descriptor
   typedef struct packed {
      logic                 first_in_container;
      logic [ID_W-1:0]      msg_ident;
      logic [FLAGS_W-1:0]   msg_flags;
      logic [KIND_W-1:0]    part_kind;
      logic [SIZE_W-1:0]    part_size;
      logic [SIZE_W-1:0]    space_left;
      logic [SIZE_W-1:0]    name_len;
      logic [VSIZE_W-1:0]   value_len;
      logic                 terminator_ok;
   } req_item_type;

   // one result
   typedef struct packed {
      logic [STAT_W-1:0]    status;
      logic [CAUSE_W-1:0]   error_cause;
      logic                 historic;
      logic [ID_W-1:0]      out_msg_ident;
      logic [FLAGS_W-1:0]   out_flags;
      logic                 message_done;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: design/mpsc_if.sv
// channel interfaces: part descriptors in, results out, register write port
`default_nettype none

interface mpsc_req_if import mpsc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 first_in_container;
   logic [ID_W-1:0]      msg_ident;
   logic [FLAGS_W-1:0]   msg_flags;
   logic [KIND_W-1:0]    part_kind;
   logic [SIZE_W-1:0]    part_size;
   logic [SIZE_W-1:0]    space_left;
   logic [SIZE_W-1:0]    name_len;
   logic [VSIZE_W-1:0]   value_len;
   logic                 terminator_ok;

   modport source (
      output valid, first_in_container, msg_ident, msg_flags, part_kind,
             part_size, space_left, name_len, value_len, terminator_ok,
      input  ready
   );
   modport sink (
      input  valid, first_in_container, msg_ident, msg_flags, part_kind,
             part_size, space_left, name_len, value_len, terminator_ok,
      output ready
   );
endinterface

interface mpsc_rsp_if import mpsc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic [CAUSE_W-1:0]   error_cause;
   logic                 historic;
   logic [ID_W-1:0]      out_msg_ident;
   logic [FLAGS_W-1:0]   out_flags;
   logic                 message_done;

   modport source (
      output valid, status, error_cause, historic, out_msg_ident, out_flags,
             message_done,
      input  ready
   );
   modport sink (
      input  valid, status, error_cause, historic, out_msg_ident, out_flags,
             message_done,
      output ready
   );
endinterface

interface mpsc_csr_if import mpsc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FLAGS_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: design/message_part_sequence_checker.sv
// message part sequence checker: order, size and identity checks per part
//
// Usage
//   req : one part descriptor per item (valid/ready). The descriptor is
//         registered on acceptance and checked against the message state in
//         the following cycle.
//   rsp : one result per item (valid/ready): delivered, error with cause, or
//         dropped, with the latched message id and flags.
//   csr : write-only port for the historic flag mask, always ready. Write it
//         only while no item is in flight.
// Path    : an accepted item passes the input register, then the result
//           register, before its result shows on rsp.
// Throughput: one item per cycle while rsp takes its results. The input
//           register and the result register both advance in the same
//           cycle, so req stays ready while a result is being taken.
// Stall: when rsp is not taken, the result register holds; one more item
//        may wait in the input register, after which req.ready drops.
// Reset: synchronous, active high. Clears the mask, the message state (start
//        phase, id, flags, value counts, drop flag) and both valid flags.
`default_nettype none

module message_part_sequence_checker import mpsc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   mpsc_req_if.sink   req,
   mpsc_rsp_if.source rsp,
   mpsc_csr_if.sink   csr
);

   // message phases
   localparam logic [1:0] PH_START    = 2'd0;
   localparam logic [1:0] PH_METHOD   = 2'd1;
   localparam logic [1:0] PH_MODIFIER = 2'd2;
   localparam logic [1:0] PH_DATA     = 2'd3;

   localparam int DIFF_W = SIZE_W + 2;

   logic [FLAGS_W-1:0] mask_ff;

   logic               in_valid_ff;
   req_item_type       in_item_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff;
   rsp_item_type       rsp_item_in;

   logic [1:0]         phase_ff,    phase_in;
   logic [ID_W-1:0]    held_id_ff,  held_id_in;
   logic [FLAGS_W-1:0] held_flags_ff, held_flags_in;
   logic [VSIZE_W-1:0] val_exp_ff,  val_exp_in;
   logic [VSIZE_W-1:0] val_rcv_ff,  val_rcv_in;
   logic               dropping_ff, dropping_in;

   logic               advance;

   // check intermediates
   logic               is_first;
   logic               at_start;
   logic [ID_W-1:0]    eff_id;
   logic [FLAGS_W-1:0] eff_flags;
   logic [DIFF_W-1:0]  mod_diff;
   logic [SIZE_W-1:0]  mod_got;
   logic [SIZE_W-1:0]  cont_bytes;
   logic [VSIZE_W:0]   cont_sum;
   logic [CAUSE_W-1:0] cause;

   // handshakes
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign csr.ready = 1'b1;

   // result port
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_item_ff.status;
   assign rsp.error_cause    = rsp_item_ff.error_cause;
   assign rsp.historic       = rsp_item_ff.historic;
   assign rsp.out_msg_ident  = rsp_item_ff.out_msg_ident;
   assign rsp.out_flags      = rsp_item_ff.out_flags;
   assign rsp.message_done   = rsp_item_ff.message_done;

   // historic mask register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr.valid) begin
         mask_ff <= csr.data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_item_ff.first_in_container <= req.first_in_container;
         in_item_ff.msg_ident          <= req.msg_ident;
         in_item_ff.msg_flags          <= req.msg_flags;
         in_item_ff.part_kind          <= req.part_kind;
         in_item_ff.part_size          <= req.part_size;
         in_item_ff.space_left         <= req.space_left;
         in_item_ff.name_len           <= req.name_len;
         in_item_ff.value_len          <= req.value_len;
         in_item_ff.terminator_ok      <= req.terminator_ok;
      end
   end

   // shared arithmetic for modifier and continuation parts
   assign mod_diff   = {2'b00, in_item_ff.part_size} - {2'b00, in_item_ff.name_len}
                     - DIFF_W'(MODIFIER_HEAD_SIZE + 1);
   assign mod_got    = mod_diff[SIZE_W-1:0];
   assign cont_bytes = in_item_ff.part_size - SIZE_W'(PART_HDR_SIZE);
   assign cont_sum   = {1'b0, val_rcv_ff} + {{(VSIZE_W + 1 - SIZE_W){1'b0}}, cont_bytes};

   // identity latch view and error cause, in check order
   always_comb begin
      is_first  = in_item_ff.first_in_container;
      at_start  = (phase_ff == PH_START);
      eff_id    = (is_first && at_start) ? in_item_ff.msg_ident : held_id_ff;
      eff_flags = (is_first && at_start) ? in_item_ff.msg_flags : held_flags_ff;
      cause     = CAUSE_NONE;
      if (is_first && !at_start && in_item_ff.msg_ident != held_id_ff) begin
         cause = CAUSE_ID;
      end else if (is_first && !at_start && in_item_ff.msg_flags != held_flags_ff) begin
         cause = CAUSE_FLAGS;
      end else if (in_item_ff.part_size < SIZE_W'(PART_HDR_SIZE)
                   || in_item_ff.part_size > in_item_ff.space_left) begin
         cause = CAUSE_SIZE;
      end else begin
         case (in_item_ff.part_kind)
            KIND_METHOD: begin
               if (in_item_ff.part_size < SIZE_W'(METHOD_MIN_SIZE)) begin
                  cause = CAUSE_MIN_SIZE;
               end else if (!at_start) begin
                  cause = CAUSE_METHOD_ORDER;
               end else if (!in_item_ff.terminator_ok) begin
                  cause = CAUSE_METHOD_TERM;
               end
            end
            KIND_MODIFIER: begin
               if (in_item_ff.part_size < SIZE_W'(MODIFIER_HEAD_SIZE)) begin
                  cause = CAUSE_MIN_SIZE;
               end else if (phase_ff != PH_METHOD && phase_ff != PH_MODIFIER) begin
                  cause = CAUSE_MOD_ORDER;
               end else if (mod_diff[DIFF_W-1] || !in_item_ff.terminator_ok) begin
                  cause = CAUSE_MOD_FORMAT;
               end else if (in_item_ff.value_len
                            < {{(VSIZE_W - SIZE_W){1'b0}}, mod_got}) begin
                  cause = CAUSE_MOD_FORMAT;
               end
            end
            KIND_MOD_CONT: begin
               if (phase_ff != PH_MODIFIER || cont_sum > {1'b0, val_exp_ff}) begin
                  cause = CAUSE_CONT;
               end
            end
            KIND_DATA: begin
               if (at_start || val_exp_ff != val_rcv_ff) begin
                  cause = CAUSE_DATA;
               end
            end
            KIND_END, KIND_CANCEL: begin
               if (in_item_ff.part_size != SIZE_W'(PART_HDR_SIZE)) begin
                  cause = CAUSE_MIN_SIZE;
               end
            end
            default: begin
               cause = CAUSE_TYPE;
            end
         endcase
      end
   end

   // next message state and result
   always_comb begin
      phase_in      = phase_ff;
      held_id_in    = held_id_ff;
      held_flags_in = held_flags_ff;
      val_exp_in    = val_exp_ff;
      val_rcv_in    = val_rcv_ff;
      dropping_in   = dropping_ff;

      rsp_item_in.status         = STAT_DELIVERED;
      rsp_item_in.error_cause    = CAUSE_NONE;
      rsp_item_in.historic       = |(eff_flags & mask_ff);
      rsp_item_in.out_msg_ident  = eff_id;
      rsp_item_in.out_flags      = eff_flags;
      rsp_item_in.message_done   = 1'b0;

      if (!is_first && dropping_ff) begin
         rsp_item_in.status = STAT_DROPPED;
      end else if (cause != CAUSE_NONE) begin
         rsp_item_in.status      = STAT_ERROR;
         rsp_item_in.error_cause = cause;
         phase_in      = PH_START;
         held_id_in    = '0;
         held_flags_in = '0;
         val_exp_in    = '0;
         val_rcv_in    = '0;
         dropping_in   = 1'b1;
      end else begin
         dropping_in   = 1'b0;
         held_id_in    = eff_id;
         held_flags_in = eff_flags;
         if (is_first && at_start) begin
            val_exp_in = '0;
            val_rcv_in = '0;
         end
         case (in_item_ff.part_kind)
            KIND_METHOD: begin
               phase_in = PH_METHOD;
            end
            KIND_MODIFIER: begin
               phase_in   = PH_MODIFIER;
               val_exp_in = in_item_ff.value_len;
               val_rcv_in = {{(VSIZE_W - SIZE_W){1'b0}}, mod_got};
            end
            KIND_MOD_CONT: begin
               val_rcv_in = cont_sum[VSIZE_W-1:0];
            end
            KIND_DATA: begin
               phase_in = PH_DATA;
            end
            default: begin
               // end or cancel closes the message
               rsp_item_in.message_done = 1'b1;
               phase_in      = PH_START;
               held_id_in    = '0;
               held_flags_in = '0;
               val_exp_in    = '0;
               val_rcv_in    = '0;
            end
         endcase
      end
   end

   // message state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         held_id_ff    <= '0;
         held_flags_ff <= '0;
         val_exp_ff    <= '0;
         val_rcv_ff    <= '0;
         dropping_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         held_id_ff    <= held_id_in;
         held_flags_ff <= held_flags_in;
         val_exp_ff    <= val_exp_in;
         val_rcv_ff    <= val_rcv_in;
         dropping_ff   <= dropping_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // an error leaves the block in the start phase, dropping later parts
   a_error_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_item_in.status == STAT_ERROR
      |=> phase_ff == PH_START && dropping_ff && held_id_ff == '0)
      else $error("error did not return the block to the start phase");

   // a finished message clears the value counts
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_item_in.message_done
      |=> phase_ff == PH_START && val_exp_ff == '0 && val_rcv_ff == '0)
      else $error("finished message left state behind");

   // in the modifier phase, received value bytes never pass the expected count
   a_value_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_MODIFIER |-> val_rcv_ff <= val_exp_ff)
      else $error("modifier value bytes exceed the declared size");

   // a dropped item changes no state
   a_drop_keeps_state: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_item_in.status == STAT_DROPPED
      |=> $stable(phase_ff) && $stable(held_id_ff) && dropping_ff)
      else $error("dropped item changed the message state");

   // input side only stalls when both stages are full and the output waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> in_valid_ff && rsp_valid_ff && !rsp.ready)
      else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

FILE: tb/part_order_monitor.sv
// watches the part, result and mask channels, predicts each result and compares
module part_order_monitor import mpsc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   mpsc_req_if         req_bus,
   mpsc_rsp_if         rsp_bus,
   mpsc_csr_if         csr_bus,
   output int          fail_count,
   output int          pending_results,
   output int          results_checked,
   output int          messages_done,
   output logic [15:0] causes_seen,
   output logic [2:0]  statuses_seen
);

   typedef enum logic [2:0] {
      PH_START,
      PH_METHOD,
      PH_MODIFIER,
      PH_DATA
   } msg_phase_type;

   // message state as the block should hold it
   msg_phase_type       phase;
   logic [ID_W-1:0]     held_id;
   logic [FLAGS_W-1:0]  held_flags;
   logic [VSIZE_W-1:0]  value_expected;
   logic [VSIZE_W-1:0]  value_received;
   logic                dropping;
   logic [FLAGS_W-1:0]  historic_mask;

   rsp_item_type        expected_results[$];
   int                  mismatches = 0;

   function automatic void clear_message();
      phase          = PH_START;
      held_id        = '0;
      held_flags     = '0;
      value_expected = '0;
      value_received = '0;
   endfunction

   // result fields that report the held message identity
   function automatic rsp_item_type stamp_result(logic [STAT_W-1:0] status,
                                                 logic [CAUSE_W-1:0] cause,
                                                 logic done);
      rsp_item_type r;
      r.status         = status;
      r.error_cause    = cause;
      r.historic       = |(held_flags & historic_mask);
      r.out_msg_ident  = held_id;
      r.out_flags      = held_flags;
      r.message_done   = done;
      return r;
   endfunction

   // works out the result of one part and advances the message state
   function automatic rsp_item_type judge_part(input req_item_type p);
      logic [CAUSE_W-1:0] cause;
      logic               done;
      logic [16:0]        head;
      logic [16:0]        got;
      logic [32:0]        sum;
      rsp_item_type       r;
      cause = CAUSE_NONE;
      done  = 1'b0;
      // a new container is always checked, otherwise a failed one drops the rest
      if (p.first_in_container) begin
         dropping = 1'b0;
         if (phase == PH_START) begin
            held_id        = p.msg_ident;
            held_flags     = p.msg_flags;
            value_expected = '0;
            value_received = '0;
         end else if (p.msg_ident != held_id) begin
            cause = CAUSE_ID;
         end else if (p.msg_flags != held_flags) begin
            cause = CAUSE_FLAGS;
         end
      end else if (dropping) begin
         r = stamp_result(STAT_DROPPED, CAUSE_NONE, 1'b0);
         return r;
      end
      // generic size and type checks, then the one for the kind
      if (cause == CAUSE_NONE) begin
         if (p.part_size < PART_HDR_SIZE || p.part_size > p.space_left) begin
            cause = CAUSE_SIZE;
         end else if (p.part_kind > KIND_CANCEL) begin
            cause = CAUSE_TYPE;
         end else begin
            case (p.part_kind)
               KIND_METHOD: begin
                  if (p.part_size < METHOD_MIN_SIZE) cause = CAUSE_MIN_SIZE;
                  else if (phase != PH_START) cause = CAUSE_METHOD_ORDER;
                  else if (!p.terminator_ok) cause = CAUSE_METHOD_TERM;
                  else phase = PH_METHOD;
               end
               KIND_MODIFIER: begin
                  head = 17'(MODIFIER_HEAD_SIZE) + 17'(p.name_len) + 17'd1;
                  got  = 17'(p.part_size) - head;
                  if (p.part_size < MODIFIER_HEAD_SIZE) begin
                     cause = CAUSE_MIN_SIZE;
                  end else if (phase != PH_METHOD && phase != PH_MODIFIER) begin
                     cause = CAUSE_MOD_ORDER;
                  end else if (17'(p.part_size) < head || !p.terminator_ok) begin
                     cause = CAUSE_MOD_FORMAT;
                  end else if (p.value_len < 32'(got)) begin
                     cause = CAUSE_MOD_FORMAT;
                  end else begin
                     value_expected = p.value_len;
                     value_received = 32'(got);
                     phase          = PH_MODIFIER;
                  end
               end
               KIND_MOD_CONT: begin
                  // value bytes summed without wrapping
                  sum = {1'b0, value_received} + 33'(p.part_size - 16'(PART_HDR_SIZE));
                  if (phase != PH_MODIFIER || sum > {1'b0, value_expected})
                     cause = CAUSE_CONT;
                  else
                     value_received = sum[31:0];
               end
               KIND_DATA: begin
                  if (phase == PH_START || value_expected != value_received)
                     cause = CAUSE_DATA;
                  else
                     phase = PH_DATA;
               end
               default: begin
                  if (p.part_size != PART_HDR_SIZE) cause = CAUSE_MIN_SIZE;
                  else done = 1'b1;
               end
            endcase
         end
      end
      // held values are reported before any clearing
      if (cause != CAUSE_NONE) begin
         r = stamp_result(STAT_ERROR, cause, 1'b0);
         clear_message();
         dropping = 1'b1;
      end else begin
         r = stamp_result(STAT_DELIVERED, CAUSE_NONE, done);
         if (done) clear_message();
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // sample all three channels at each edge
   always @(posedge clock) begin
      req_item_type part;
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         historic_mask = '0;
         dropping      = 1'b0;
         clear_message();
         expected_results.delete();
         results_checked <= 0;
         messages_done   <= 0;
         causes_seen     <= '0;
         statuses_seen   <= '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready)
            historic_mask = csr_bus.data;
         // compare a taken result with the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status         = rsp_bus.status;
            got.error_cause    = rsp_bus.error_cause;
            got.historic       = rsp_bus.historic;
            got.out_msg_ident  = rsp_bus.out_msg_ident;
            got.out_flags      = rsp_bus.out_flags;
            got.message_done   = rsp_bus.message_done;
            if (expected_results.size() == 0) begin
               mismatches++;
               $error("result taken with no part waiting for one");
            end else begin
               want = expected_results.pop_front();
               check_field("status", 64'(want.status), 64'(got.status));
               check_field("error_cause", 64'(want.error_cause), 64'(got.error_cause));
               check_field("historic", 64'(want.historic), 64'(got.historic));
               check_field("out_msg_ident", want.out_msg_ident, got.out_msg_ident);
               check_field("out_flags", 64'(want.out_flags), 64'(got.out_flags));
               check_field("message_done", 64'(want.message_done), 64'(got.message_done));
               results_checked <= results_checked + 1;
               statuses_seen   <= statuses_seen | (3'b001 << want.status);
               if (want.status == STAT_ERROR)
                  causes_seen <= causes_seen | (16'd1 << want.error_cause);
               if (want.message_done)
                  messages_done <= messages_done + 1;
            end
         end
         // predict the result of an accepted part
         if (req_bus.valid && req_bus.ready) begin
            part.first_in_container = req_bus.first_in_container;
            part.msg_ident          = req_bus.msg_ident;
            part.msg_flags          = req_bus.msg_flags;
            part.part_kind          = req_bus.part_kind;
            part.part_size          = req_bus.part_size;
            part.space_left         = req_bus.space_left;
            part.name_len           = req_bus.name_len;
            part.value_len          = req_bus.value_len;
            part.terminator_ok      = req_bus.terminator_ok;
            expected_results.push_back(judge_part(part));
         end
      end
      fail_count      <= mismatches;
      pending_results <= expected_results.size();
   end

endmodule

FILE: tb/tb.sv
// top of the bench: clock, reset, part and mask stimulus, result back-pressure, verdict
module tb import mpsc_pkg::*; ();

   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd7;
   localparam int LONG_HOLD   = 48;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 140;

   logic clock = 1'b0;
   logic reset;

   mpsc_req_if req_bus();
   mpsc_rsp_if rsp_bus();
   mpsc_csr_if csr_bus();

   int          fail_count;
   int          pending_results;
   int          results_checked;
   int          messages_done;
   logic [15:0] causes_seen;
   logic [2:0]  statuses_seen;

   int items_sent    = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int quiet_cycles  = 0;

   message_part_sequence_checker dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   part_order_monitor order_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_checked (results_checked),
      .messages_done   (messages_done),
      .causes_seen     (causes_seen),
      .statuses_seen   (statuses_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len(int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic req_item_type make_part(bit first, logic [63:0] id, logic [31:0] flags,
                                              logic [KIND_W-1:0] kind, int size, int space,
                                              int nsize, logic [31:0] vsize, bit term);
      req_item_type p;
      p.first_in_container = first;
      p.msg_ident          = id;
      p.msg_flags          = flags;
      p.part_kind          = kind;
      p.part_size          = 16'(size);
      p.space_left         = 16'(space);
      p.name_len           = 16'(nsize);
      p.value_len          = vsize;
      p.terminator_ok      = term;
      return p;
   endfunction

   // a well-formed part of a message, with random slack and unused fields
   function automatic req_item_type shape_part(bit first, logic [63:0] id, logic [31:0] flags,
                                               logic [KIND_W-1:0] kind, int size);
      int  space;
      bit  term;
      space = size + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200));
      if (space > 65535) space = 65535;
      term = (kind == KIND_METHOD || kind == KIND_MODIFIER) ? 1'b1 : 1'($urandom_range(0, 1));
      return make_part(first || ($urandom_range(0, 4) == 0), id, flags, kind, size, space,
                       $urandom, $urandom, term);
   endfunction

   // offer one part and wait until it is taken
   task automatic send_part(input req_item_type p);
      int gap;
      gap = idle_len(req_idle_pct);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid              <= 1'b1;
      req_bus.first_in_container <= p.first_in_container;
      req_bus.msg_ident          <= p.msg_ident;
      req_bus.msg_flags          <= p.msg_flags;
      req_bus.part_kind          <= p.part_kind;
      req_bus.part_size          <= p.part_size;
      req_bus.space_left         <= p.space_left;
      req_bus.name_len           <= p.name_len;
      req_bus.value_len          <= p.value_len;
      req_bus.terminator_ok      <= p.terminator_ok;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic await_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic set_historic_mask(input logic [31:0] mask);
      await_drain();
      repeat (3) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= mask;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // one message in order, sometimes broken on purpose
   task automatic send_message();
      req_item_type parts[$];
      req_item_type p;
      int           chunks[$];
      logic [63:0]  id;
      logic [31:0]  flags;
      int           nsz;
      int           got;
      int           total;
      int           chunk;
      int           idx;
      id    = {$urandom, $urandom};
      flags = $urandom;
      parts.push_back(shape_part(1'b1, id, flags, KIND_METHOD, $urandom_range(8, 64)));
      repeat ($urandom_range(0, 3)) begin
         nsz   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 16);
         got   = $urandom_range(0, 24);
         total = got;
         chunks.delete();
         repeat ($urandom_range(0, 3)) begin
            chunk = $urandom_range(0, 40);
            chunks.push_back(chunk);
            total += chunk;
         end
         p = shape_part(1'b0, id, flags, KIND_MODIFIER, MODIFIER_HEAD_SIZE + nsz + 1 + got);
         p.name_len  = 16'(nsz);
         p.value_len = 32'(total);
         parts.push_back(p);
         foreach (chunks[i])
            parts.push_back(shape_part(1'b0, id, flags, KIND_MOD_CONT,
                                       PART_HDR_SIZE + chunks[i]));
      end
      if ($urandom_range(0, 4) != 0)
         parts.push_back(shape_part(1'b0, id, flags, KIND_DATA, $urandom_range(4, 300)));
      parts.push_back(shape_part(1'b0, id, flags,
                                 $urandom_range(0, 1) ? KIND_END : KIND_CANCEL, PART_HDR_SIZE));
      // damage one part now and then
      if ($urandom_range(0, 3) == 0) begin
         idx = $urandom_range(0, parts.size() - 1);
         p   = parts[idx];
         case ($urandom_range(0, 7))
            0: p.part_kind = KIND_W'($urandom_range(0, 7));
            1: p.part_size = 16'($urandom_range(0, 15));
            2: p.space_left = p.part_size - 16'd1;
            3: p.terminator_ok = 1'b0;
            4: begin
               p.first_in_container = 1'b1;
               p.msg_ident[$urandom_range(0, 63)] ^= 1'b1;
            end
            5: begin
               p.first_in_container = 1'b1;
               p.msg_flags[$urandom_range(0, 31)] ^= 1'b1;
            end
            6: p.value_len = $urandom;
            default: p.first_in_container = ~p.first_in_container;
         endcase
         parts[idx] = p;
         if ($urandom_range(0, 3) == 0) parts.delete($urandom_range(0, parts.size() - 1));
      end
      foreach (parts[i]) send_part(parts[i]);
   endtask

   // mostly whole messages, some loose random parts
   task automatic send_random_traffic();
      req_item_type p;
      int           size;
      if ($urandom_range(0, 99) < 12) begin
         size = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 80);
         p = make_part(1'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom,
                       KIND_W'($urandom_range(0, 7)), size,
                       $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                            : size + $urandom_range(0, 20),
                       $urandom_range(0, 65535), $urandom, 1'($urandom_range(0, 1)));
         send_part(p);
      end else begin
         send_message();
      end
   endtask

   // result side: random stalls plus long hold-offs on request
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            stall = LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall = idle_len(rsp_idle_pct);
            if (stall > 0) begin
               stall--;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // main stimulus
   initial begin
      logic [31:0] id_all;
      int          target;
      int          burst_end;
      int          saved_pct;
      id_all = '1;
      reset                      <= 1'b1;
      req_bus.valid              <= 1'b0;
      req_bus.first_in_container <= 1'b0;
      req_bus.msg_ident          <= '0;
      req_bus.msg_flags          <= '0;
      req_bus.part_kind          <= KIND_METHOD;
      req_bus.part_size          <= '0;
      req_bus.space_left         <= '0;
      req_bus.name_len           <= '0;
      req_bus.value_len          <= '0;
      req_bus.terminator_ok      <= 1'b0;
      csr_bus.valid              <= 1'b0;
      csr_bus.data               <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed parts: every kind, every cause, drops and a new container
      set_historic_mask(32'h0000_0001);
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      send_part(make_part(1, '1, id_all, KIND_METHOD, 8, 8, 0, 0, 1));
      send_part(make_part(0, '1, id_all, KIND_MODIFIER, 21, 30, 3, 9, 1));
      send_part(make_part(1, '1, id_all, KIND_MOD_CONT, 8, 8, 0, 0, 0));
      send_part(make_part(0, '1, id_all, KIND_DATA, 4, 4, 0, 0, 0));
      send_part(make_part(0, '1, id_all, KIND_CANCEL, 4, 9, 0, 0, 0));
      // modifier with no message started, then a dropped part
      send_part(make_part(0, 64'h5, 32'h5, KIND_MODIFIER, 21, 30, 3, 9, 1));
      send_part(make_part(0, 64'h5, 32'h5, KIND_DATA, 4, 4, 0, 0, 1));
      send_part(make_part(1, 64'h0, 32'h0, KIND_METHOD, 65535, 65535, 65535, '1, 1));
      send_part(make_part(1, 64'h1, 32'h0, KIND_DATA, 4, 4, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h3, KIND_METHOD, 10, 10, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h2, KIND_METHOD, 10, 10, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h3, KIND_METHOD, 7, 100, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h3, KIND_METHOD, 20, 19, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h3, KIND_UNKNOWN, 4, 4, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h3, KIND_METHOD, 8, 8, 0, 0, 0));
      send_part(make_part(1, 64'h9, 32'h3, KIND_METHOD, 8, 8, 0, 0, 1));
      send_part(make_part(0, 64'h9, 32'h3, KIND_METHOD, 8, 8, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h3, KIND_METHOD, 8, 8, 0, 0, 1));
      send_part(make_part(0, 64'h9, 32'h3, KIND_MODIFIER, 12, 12, 10, 0, 1));
      // huge modifier and continuation, then data before the value is complete
      send_part(make_part(1, 64'h9, 32'h3, KIND_METHOD, 8, 8, 0, 0, 1));
      send_part(make_part(0, 64'h9, 32'h3, KIND_MODIFIER, 65535, 65535, 60000, '1, 1));
      send_part(make_part(0, 64'h9, 32'h3, KIND_MOD_CONT, 65535, 65535, 0, 0, 1));
      send_part(make_part(0, 64'h9, 32'h3, KIND_DATA, 4, 4, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h3, KIND_MODIFIER, 11, 11, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h3, KIND_MOD_CONT, 8, 8, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h3, KIND_END, 5, 5, 0, 0, 1));
      send_part(make_part(1, 64'h9, 32'h3, KIND_END, 4, 4, 0, 0, 1));
      // continuation that overflows the declared value size
      send_part(make_part(1, 64'h9, 32'h3, KIND_METHOD, 8, 8, 0, 0, 1));
      send_part(make_part(0, 64'h9, 32'h3, KIND_MODIFIER, 13, 13, 0, 2, 1));
      send_part(make_part(0, 64'h9, 32'h3, KIND_MOD_CONT, 7, 7, 0, 0, 1));

      // random phases, each with its own mask and idling
      for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
         case (phase_no % 4)
            0: set_historic_mask('1);
            1: set_historic_mask('0);
            2: set_historic_mask(32'h1 << $urandom_range(0, 31));
            default: set_historic_mask($urandom);
         endcase
         if (phase_no == 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = $urandom_range(10, 50);
            rsp_idle_pct = $urandom_range(10, 50);
         end
         target = items_sent + PHASE_ITEMS;
         // result side held off while parts keep coming, then a full pause
         if (phase_no == 3 || phase_no == 6) begin
            saved_pct = req_idle_pct;
            req_idle_pct = 0;
            hold_requests++;
            burst_end = items_sent + 12;
            while (items_sent < burst_end) send_random_traffic();
            req_idle_pct = saved_pct;
            await_drain();
         end
         while (items_sent < target) send_random_traffic();
      end

      await_drain();
      repeat (4) @(posedge clock);
      $display("sent %0d parts, checked %0d results, %0d messages finished",
               items_sent, results_checked, messages_done);
      $display("statuses seen %b, error causes seen %b (bit n for cause n)",
               statuses_seen, causes_seen);
      if (fail_count == 0 && pending_results == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
